// ===== rtl/spc_pkg.sv =====
// Shared types and constants for the spectrum scope pixel colourer.
// Used by spc_ramp and spectrum_scope_pixel_colourer; depends on nothing.
package spc_pkg;

   // Fixed field widths
   localparam int ROW_W      = 7;
   localparam int LEVEL_W    = 8;
   localparam int COLOUR_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ZOOM_W     = 5;
   localparam int BIN_W      = 7;

   localparam int LEVEL_VALUES = 2 ** LEVEL_W;
   localparam int ROW_VALUES   = 2 ** ROW_W;
   localparam int ZOOM_VALUES  = 2 ** ZOOM_W;

   // Level scaling is rows * level / 270
   localparam int SCALE_DEN = 270;
   // Row ramp index spans 0..255
   localparam int RAMP_SPAN = 256;
   localparam int RAMP_MAX  = 255;
   // Column tick spacing: columns * zoom / 30, times 5 below zoom 3
   localparam int TICK_DEN      = 30;
   localparam int TICK_LOW_MUL  = 5;
   localparam int TICK_ZOOM_MIN = 3;
   // Row tick reciprocal precision
   localparam int ROW_RCP_SHIFT = 16;

   // Fixed colours (RGB565)
   localparam logic [COLOUR_W-1:0] COLOUR_TRACE     = 16'hFFFF;
   localparam logic [COLOUR_W-1:0] COLOUR_HOLD_FILL = 16'hFC10;
   localparam logic [COLOUR_W-1:0] COLOUR_HOLD_LINE = 16'hF800;

   // Register reset values
   localparam logic [COLOUR_W-1:0] GRID_RESET = 16'h8410;
   localparam logic [ZOOM_W-1:0]   ZOOM_RESET = 5'd1;

   typedef enum logic {
      CMD_SCOPE     = 1'b0,
      CMD_WATERFALL = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_START = 3'd0,
      CSR_FILTER_STOP  = 3'd1,
      CSR_USB_ON       = 3'd2,
      CSR_LSB_ON       = 3'd3,
      CSR_ZOOM         = 3'd4,
      CSR_LEVEL_10DB   = 3'd5,
      CSR_HOLD_ENABLE  = 3'd6,
      CSR_GRID_COLOUR  = 3'd7
   } csr_index_type;

   // Heat ramp segments
   typedef enum logic [2:0] {
      SEG_BLACK_BLUE  = 3'd0,
      SEG_BLUE_CYAN   = 3'd1,
      SEG_CYAN_GREEN  = 3'd2,
      SEG_GREEN_YEL   = 3'd3,
      SEG_YEL_RED     = 3'd4,
      SEG_RED_WHITE   = 3'd5
   } ramp_seg_type;

   // Ramp modifiers
   typedef struct packed {
      logic blend;
      logic highlight;
   } ramp_ctl_type;

endpackage

// ===== rtl/spectrum_scope_pixel_colourer.sv =====
// Spectrum scope / waterfall pixel colourer, top level.
// Throughput: one request per clock; four register stages (table lookup,
// reciprocal multiply, remainder check and classify, ramp and output).
// The receiver cannot stall and busy stays low. Synchronous reset clears
// all valid bits and loads the register reset values.
module spectrum_scope_pixel_colourer #(
   parameter int COLUMNS    = 256,
   parameter int SCOPE_ROWS = 80
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [spc_pkg::ROW_W-1:0]           req_row,
   input  logic [$clog2(COLUMNS)-1:0]          req_column,
   input  logic [spc_pkg::LEVEL_W-1:0]         req_level,
   input  logic [spc_pkg::LEVEL_W-1:0]         req_level_left,
   input  logic [spc_pkg::LEVEL_W-1:0]         req_hold_level,
   input  logic [spc_pkg::LEVEL_W-1:0]         req_hold_right,
   output logic                                rsp_valid,
   output logic [spc_pkg::COLOUR_W-1:0]        rsp_pixel_colour,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Widths derived from the column count
   localparam int CW  = $clog2(COLUMNS);           // column / |bin| width
   localparam int SW  = CW + 1;                    // tick spacing width
   localparam int CK  = 2 * CW + 2;                // column reciprocal shift
   localparam int CPW = CW + CK + 1;               // column product width
   localparam int FW  = (CW + 2 > 13) ? CW + 2 : 13; // signed bin compare width
   localparam int LW  = spc_pkg::LEVEL_W;
   localparam int RW  = spc_pkg::ROW_W;
   localparam int RRW = spc_pkg::ROW_RCP_SHIFT + 1;
   localparam int RPW = RW + RRW;
   localparam int EW  = spc_pkg::BIN_W + spc_pkg::ZOOM_W;

   // ------------------------------------------------------------------
   // Constant tables built at elaboration
   // ------------------------------------------------------------------
   logic [LW-1:0]  scale_tab [spc_pkg::LEVEL_VALUES];
   logic [RRW-1:0] rrcp_tab  [spc_pkg::LEVEL_VALUES];
   logic [LW-1:0]  idx_tab   [spc_pkg::ROW_VALUES];
   logic [SW-1:0]  space_tab [spc_pkg::ZOOM_VALUES];
   logic [CK:0]    crcp_tab  [spc_pkg::ZOOM_VALUES];

   for (genvar gl = 0; gl < spc_pkg::LEVEL_VALUES; gl++) begin : g_scale
      localparam int SC  = (SCOPE_ROWS * gl) / spc_pkg::SCALE_DEN;
      localparam int SCD = (SC == 0) ? 1 : SC;
      localparam int RR  = (SC == 0) ? 0 :
                           ((1 << spc_pkg::ROW_RCP_SHIFT) + SCD - 1) / SCD;
      assign scale_tab[gl] = LW'(SC);
      assign rrcp_tab[gl]  = RRW'(RR);
   end

   for (genvar gr = 0; gr < spc_pkg::ROW_VALUES; gr++) begin : g_idx
      localparam int IX = (gr * spc_pkg::RAMP_SPAN) / SCOPE_ROWS;
      assign idx_tab[gr] = (IX > spc_pkg::RAMP_MAX) ? LW'(spc_pkg::RAMP_MAX) : LW'(IX);
   end

   for (genvar gz = 0; gz < spc_pkg::ZOOM_VALUES; gz++) begin : g_space
      localparam int SP  = (gz >= spc_pkg::TICK_ZOOM_MIN)
                           ? (COLUMNS * gz) / spc_pkg::TICK_DEN
                           : (COLUMNS * gz * spc_pkg::TICK_LOW_MUL) / spc_pkg::TICK_DEN;
      localparam int SPD = (SP == 0) ? 1 : SP;
      localparam longint CR = (SP == 0) ? 0 : ((64'd1 << CK) + SPD - 1) / SPD;
      assign space_tab[gz] = SW'(SP);
      assign crcp_tab[gz]  = (CK + 1)'(CR);
   end

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [spc_pkg::BIN_W-1:0]    fstart_ff, fstop_ff;
   logic                         usb_ff, lsb_ff, hold_en_ff;
   logic [spc_pkg::ZOOM_W-1:0]   zoom_ff;
   logic [LW-1:0]                lp10_ff;
   logic [spc_pkg::COLOUR_W-1:0] grid_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fstart_ff  <= '0;
         fstop_ff   <= '0;
         usb_ff     <= 1'b0;
         lsb_ff     <= 1'b0;
         zoom_ff    <= spc_pkg::ZOOM_RESET;
         lp10_ff    <= '0;
         hold_en_ff <= 1'b0;
         grid_ff    <= spc_pkg::GRID_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (spc_pkg::csr_index_type'(csr_index))
            spc_pkg::CSR_FILTER_START: fstart_ff  <= csr_data[spc_pkg::BIN_W-1:0];
            spc_pkg::CSR_FILTER_STOP:  fstop_ff   <= csr_data[spc_pkg::BIN_W-1:0];
            spc_pkg::CSR_USB_ON:       usb_ff     <= csr_data[0];
            spc_pkg::CSR_LSB_ON:       lsb_ff     <= csr_data[0];
            spc_pkg::CSR_ZOOM:         zoom_ff    <= csr_data[spc_pkg::ZOOM_W-1:0];
            spc_pkg::CSR_LEVEL_10DB:   lp10_ff    <= csr_data[LW-1:0];
            spc_pkg::CSR_HOLD_ENABLE:  hold_en_ff <= csr_data[0];
            spc_pkg::CSR_GRID_COLOUR:  grid_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: scale levels, row index, bin offset, lookups
   // ------------------------------------------------------------------
   logic                    req_accept;
   logic signed [FW-1:0]    fbin_in;
   logic [CW-1:0]           afb_in;

   logic                    s1_valid_ff;
   spc_pkg::cmd_type        s1_cmd_ff;
   logic [RW-1:0]           s1_row_ff;
   logic [LW-1:0]           s1_y_ff, s1_yl_ff, s1_h_ff, s1_hr_ff;
   logic [LW-1:0]           s1_idx_ff, s1_level_ff;
   logic signed [FW-1:0]    s1_fbin_ff;
   logic [CW-1:0]           s1_afb_ff;
   logic [EW-1:0]           s1_lo_ff, s1_hi_ff;
   logic [SW-1:0]           s1_space_ff;
   logic [CK:0]             s1_crcp_ff;
   logic [LW-1:0]           s1_rdiv_ff;
   logic [RRW-1:0]          s1_rrcp_ff;

   assign req_accept = start && !busy;
   assign fbin_in    = $signed(FW'(req_column)) - $signed(FW'(COLUMNS / 2));
   assign afb_in     = (fbin_in < 0) ? CW'(-fbin_in) : CW'(fbin_in);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= req_accept;
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= spc_pkg::cmd_type'(req_command);
      s1_row_ff   <= req_row;
      s1_y_ff     <= scale_tab[req_level];
      s1_yl_ff    <= scale_tab[req_level_left];
      s1_h_ff     <= scale_tab[req_hold_level] + LW'(1);
      s1_hr_ff    <= scale_tab[req_hold_right] + LW'(1);
      s1_idx_ff   <= idx_tab[req_row];
      s1_level_ff <= req_level;
      s1_fbin_ff  <= fbin_in;
      s1_afb_ff   <= afb_in;
      s1_lo_ff    <= EW'(fstart_ff) * EW'(zoom_ff);
      s1_hi_ff    <= EW'(fstop_ff) * EW'(zoom_ff);
      s1_space_ff <= space_tab[zoom_ff];
      s1_crcp_ff  <= crcp_tab[zoom_ff];
      s1_rdiv_ff  <= scale_tab[lp10_ff];
      s1_rrcp_ff  <= rrcp_tab[lp10_ff];
   end

   // ------------------------------------------------------------------
   // Stage 2: min/max, passband, reciprocal quotients
   // ------------------------------------------------------------------
   logic signed [FW-1:0]    lo_s, hi_s, nfbin;
   logic [CPW-1:0]          cprod;
   logic [RPW-1:0]          rprod;

   logic                    s2_valid_ff;
   spc_pkg::cmd_type        s2_cmd_ff;
   logic [RW-1:0]           s2_row_ff;
   logic [LW-1:0]           s2_dmin_ff, s2_dmax_ff, s2_hmin_ff, s2_hmax_ff;
   logic [LW-1:0]           s2_idx_ff, s2_level_ff;
   logic                    s2_pass_ff, s2_cursor_ff;
   logic [CW-1:0]           s2_afb_ff, s2_qc_ff;
   logic [SW-1:0]           s2_space_ff;
   logic [LW-1:0]           s2_rdiv_ff;
   logic [RW-1:0]           s2_qr_ff;

   assign lo_s  = $signed(FW'(s1_lo_ff));
   assign hi_s  = $signed(FW'(s1_hi_ff));
   assign nfbin = -s1_fbin_ff;
   assign cprod = CPW'(s1_afb_ff) * CPW'(s1_crcp_ff);
   assign rprod = RPW'(s1_row_ff) * RPW'(s1_rrcp_ff);

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_cmd_ff    <= s1_cmd_ff;
      s2_row_ff    <= s1_row_ff;
      s2_dmin_ff   <= (s1_y_ff < s1_yl_ff) ? s1_y_ff : s1_yl_ff;
      s2_dmax_ff   <= (s1_y_ff < s1_yl_ff) ? s1_yl_ff : s1_y_ff;
      s2_hmin_ff   <= (s1_h_ff < s1_hr_ff) ? s1_h_ff : s1_hr_ff;
      s2_hmax_ff   <= (s1_h_ff < s1_hr_ff) ? s1_hr_ff : s1_h_ff;
      s2_idx_ff    <= s1_idx_ff;
      s2_level_ff  <= s1_level_ff;
      s2_pass_ff   <= (usb_ff && (s1_fbin_ff > lo_s) && (s1_fbin_ff < hi_s)) ||
                      (lsb_ff && (nfbin > lo_s) && (nfbin < hi_s));
      s2_cursor_ff <= (s1_fbin_ff == '0);
      s2_afb_ff    <= s1_afb_ff;
      s2_qc_ff     <= CW'(cprod >> CK);
      s2_space_ff  <= s1_space_ff;
      s2_rdiv_ff   <= s1_rdiv_ff;
      s2_qr_ff     <= RW'(rprod >> spc_pkg::ROW_RCP_SHIFT);
   end

   // ------------------------------------------------------------------
   // Stage 3: tick check and pixel classification
   // ------------------------------------------------------------------
   logic [CW+SW-1:0]        cback;
   logic [RW+LW-1:0]        rback;
   logic                    col_tick, row_tick;
   logic [LW:0]             row_x;

   logic                    s3_valid_in, s3_use_ramp_in;
   logic [LW-1:0]           s3_value_in;
   spc_pkg::ramp_ctl_type   s3_ctl_in;
   logic [spc_pkg::COLOUR_W-1:0] s3_fixed_in;

   logic                    s3_valid_ff, s3_use_ramp_ff;
   logic [LW-1:0]           s3_value_ff;
   spc_pkg::ramp_ctl_type   s3_ctl_ff;
   logic [spc_pkg::COLOUR_W-1:0] s3_fixed_ff;

   assign cback    = (CW + SW)'(s2_qc_ff) * (CW + SW)'(s2_space_ff);
   assign rback    = (RW + LW)'(s2_qr_ff) * (RW + LW)'(s2_rdiv_ff);
   assign col_tick = (s2_space_ff != '0) && (s2_afb_ff != '0) &&
                     (cback == (CW + SW)'(s2_afb_ff));
   assign row_tick = (s2_rdiv_ff != '0) && (rback == (RW + LW)'(s2_row_ff));
   assign row_x    = (LW + 1)'(s2_row_ff);

   always_comb begin
      s3_valid_in    = s2_valid_ff;
      s3_use_ramp_in = 1'b1;
      s3_value_in    = '0;
      s3_ctl_in      = '{blend: s2_pass_ff, highlight: s2_cursor_ff};
      s3_fixed_in    = spc_pkg::COLOUR_TRACE;
      if (s2_cmd_ff == spc_pkg::CMD_WATERFALL) begin
         s3_value_in = s2_level_ff;
      end else if (row_x < (LW + 1)'(s2_dmin_ff)) begin
         // below the trace: heat ramp by row height
         s3_value_in = s2_idx_ff;
         s3_ctl_in   = '{blend: s2_pass_ff || s2_cursor_ff, highlight: s2_cursor_ff};
      end else if (row_x <= (LW + 1)'(s2_dmax_ff)) begin
         s3_use_ramp_in = 1'b0;
      end else if (hold_en_ff && row_x < (LW + 1)'(s2_hmin_ff)) begin
         s3_use_ramp_in = 1'b0;
         s3_fixed_in    = spc_pkg::COLOUR_HOLD_FILL;
      end else if (hold_en_ff && row_x <= (LW + 1)'(s2_hmax_ff)) begin
         s3_use_ramp_in = 1'b0;
         s3_fixed_in    = spc_pkg::COLOUR_HOLD_LINE;
      end else if (col_tick || row_tick) begin
         s3_use_ramp_in = 1'b0;
         s3_fixed_in    = grid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s3_valid_in;
   end

   always_ff @(posedge clock) begin
      s3_use_ramp_ff <= s3_use_ramp_in;
      s3_value_ff    <= s3_value_in;
      s3_ctl_ff      <= s3_ctl_in;
      s3_fixed_ff    <= s3_fixed_in;
   end

   // ------------------------------------------------------------------
   // Stage 4: ramp colour and output register
   // ------------------------------------------------------------------
   logic [spc_pkg::COLOUR_W-1:0] ramp_colour;
   logic                         rsp_valid_in;
   logic [spc_pkg::COLOUR_W-1:0] rsp_colour_in;
   logic                         rsp_valid_ff;
   logic [spc_pkg::COLOUR_W-1:0] rsp_colour_ff;

   spc_ramp u_ramp (
      .value  (s3_value_ff),
      .ctl    (s3_ctl_ff),
      .colour (ramp_colour)
   );

   assign rsp_valid_in  = s3_valid_ff;
   assign rsp_colour_in = s3_use_ramp_ff ? ramp_colour : s3_fixed_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_colour_ff <= rsp_colour_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_colour = rsp_colour_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // every result comes from an accepted request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without a matching request");

   // waterfall pixel on the centre cursor always gets the green highlight
   a_cursor_green: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_command == spc_pkg::CMD_WATERFALL, 4) &&
       $past(req_column == CW'(COLUMNS / 2), 4))
      |-> (rsp_pixel_colour[10:9] == 2'b11))
      else $error("cursor highlight missing on waterfall pixel");

   // with hold drawing off, a fixed colour is the hold fill only through the grid
   a_no_hold_fill: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_use_ramp_ff &&
       $past(!hold_en_ff && (grid_ff != spc_pkg::COLOUR_HOLD_FILL)))
      |-> (s3_fixed_ff != spc_pkg::COLOUR_HOLD_FILL))
      else $error("hold fill drawn with hold disabled");

endmodule

// ===== rtl/spc_ramp.sv =====
// Six-segment heat ramp with passband blend and cursor highlight, to RGB565.
// Uses spc_pkg types; purely combinational.
module spc_ramp (
   input  logic [spc_pkg::LEVEL_W-1:0]  value,
   input  spc_pkg::ramp_ctl_type        ctl,
   output logic [spc_pkg::COLOUR_W-1:0] colour
);

   logic [10:0] v;
   logic [7:0]  frac;
   logic [7:0]  r0, g0, b0;
   logic [7:0]  r1, g1, b1;
   logic [7:0]  r2, g2, b2;

   // value * 6: top bits pick the segment, low byte is the position in it
   assign v    = 11'(value) * 11'd6;
   assign frac = v[7:0];

   always_comb begin
      case (spc_pkg::ramp_seg_type'(v[10:8]))
         spc_pkg::SEG_BLACK_BLUE: begin
            r0 = 8'd0;   g0 = 8'd0;         b0 = frac;
         end
         spc_pkg::SEG_BLUE_CYAN: begin
            r0 = 8'd0;   g0 = frac;         b0 = 8'd255;
         end
         spc_pkg::SEG_CYAN_GREEN: begin
            r0 = 8'd0;   g0 = 8'd255;       b0 = 8'd255 - frac;
         end
         spc_pkg::SEG_GREEN_YEL: begin
            r0 = frac;   g0 = 8'd255;       b0 = 8'd0;
         end
         spc_pkg::SEG_YEL_RED: begin
            r0 = 8'd255; g0 = 8'd255 - frac; b0 = 8'd0;
         end
         default: begin
            r0 = 8'd255; g0 = frac;         b0 = frac;
         end
      endcase
   end

   // Passband blend: halve rounding up, lift green
   always_comb begin
      if (ctl.blend) begin
         r1 = r0 - (r0 >> 1);
         g1 = g0 - (g0 >> 1) + 8'd127;
         b1 = b0 - (b0 >> 1);
      end else begin
         r1 = r0;
         g1 = g0;
         b1 = b0;
      end
   end

   // Cursor highlight: dim red/blue, push green high
   always_comb begin
      if (ctl.highlight) begin
         r2 = r1 >> 2;
         g2 = (g1 >> 2) + 8'd192;
         b2 = b1 >> 2;
      end else begin
         r2 = r1;
         g2 = g1;
         b2 = b1;
      end
   end

   assign colour = {r2[7:3], g2[7:2], b2[7:3]};

endmodule
